### rtl/lsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

    localparam int SAMPLE_W       = 31;
    localparam int DURATION_W     = 32;
    localparam int START_W        = 31;
    localparam int HEIGHT_W       = 32;
    localparam int ROWS_W         = 20;
    localparam int TOTAL_W        = 32;
    localparam int RING_DEPTH_DEF = 32;
    localparam int EWMA_SHIFT     = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV
    } t_state;

    // Negative or zero durations count as one.
    function automatic logic [SAMPLE_W-1:0] floor_sample(input logic [DURATION_W-1:0] raw);
        logic [SAMPLE_W-1:0] res;
        if (raw[DURATION_W-1] || (raw == '0)) begin
            res = SAMPLE_W'(1);
        end else begin
            res = raw[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/lsm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lsm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/lsm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module lsm_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_acc;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;
    logic [DVS_W-1:0] n_rem;
    logic [DVD_W-1:0] n_acc;

    always_comb begin
        rem_sh  = {r_rem, r_acc[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
        n_rem   = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        // dividend bits shift out the top, quotient bits shift in below
        n_acc   = {r_acc[DVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_acc;

endmodule

`default_nettype wire

### rtl/latency_statistics_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Valid     Ready     Payload
// input     i_valid   o_ready   i_duration_sample, i_start_height, i_row_count
// output    o_valid   i_ready   o_total_count ... o_batch_rows
//
// An item passes from accept to result through the ring read and update, the
// bit-serial divider that forms the window average, and the load of the output
// register, which waits while the previous result is stalled by i_ready.
// One item is in flight at a time; the next is accepted once the result sits
// in the output register, even while that result is stalled by i_ready.
// Synchronous active-low reset clears the running statistics; ring contents are never
// used before written, so the ring needs no clearing.
module latency_statistics_monitor #(
    parameter int RING_DEPTH = lsm_pkg::RING_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [lsm_pkg::DURATION_W-1:0] i_duration_sample,
    input  wire logic        [lsm_pkg::START_W-1:0]    i_start_height,
    input  wire logic        [lsm_pkg::ROWS_W-1:0]     i_row_count,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic             [lsm_pkg::TOTAL_W-1:0]    o_total_count,
    output logic             [lsm_pkg::SAMPLE_W-1:0]   o_last_duration,
    output logic             [lsm_pkg::SAMPLE_W-1:0]   o_smoothed_duration,
    output logic             [lsm_pkg::SAMPLE_W-1:0]   o_peak_duration,
    output logic             [$clog2(RING_DEPTH+1)-1:0] o_window_samples,
    output logic             [lsm_pkg::SAMPLE_W-1:0]   o_window_average,
    output logic signed      [lsm_pkg::HEIGHT_W-1:0]   o_first_height,
    output logic signed      [lsm_pkg::HEIGHT_W-1:0]   o_last_height,
    output logic             [lsm_pkg::ROWS_W-1:0]     o_batch_rows
);

    localparam int S_W    = lsm_pkg::SAMPLE_W;
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = S_W + SLOT_W;
    localparam int H_W    = lsm_pkg::HEIGHT_W;
    localparam int T_W    = lsm_pkg::TOTAL_W;
    localparam int R_W    = lsm_pkg::ROWS_W;
    localparam int SH     = lsm_pkg::EWMA_SHIFT;

    lsm_pkg::t_state r_state, n_state;

    // item being worked on
    logic [S_W-1:0]                r_s;
    logic [lsm_pkg::START_W-1:0]   r_height;
    logic [R_W-1:0]                r_rows;

    // statistics
    logic [SLOT_W-1:0] r_slot;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [T_W-1:0]    r_total;
    logic [S_W-1:0]    r_avg;
    logic [S_W-1:0]    r_peak;
    logic [H_W-1:0]    r_low;
    logic [H_W-1:0]    r_high;

    // output register
    logic              r_out_valid;
    logic [T_W-1:0]    r_o_total;
    logic [S_W-1:0]    r_o_last;
    logic [S_W-1:0]    r_o_avg;
    logic [S_W-1:0]    r_o_peak;
    logic [FILL_W-1:0] r_o_fill;
    logic [S_W-1:0]    r_o_wavg;
    logic [H_W-1:0]    r_o_low;
    logic [H_W-1:0]    r_o_high;
    logic [R_W-1:0]    r_o_rows;

    logic              accept;
    logic              div_start;
    logic              out_load;
    logic              div_busy;
    logic [SUM_W-1:0]  div_quot;
    logic [S_W-1:0]    ring_rdata;

    logic              full;
    logic [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0] n_fill;
    logic [SLOT_W-1:0] n_slot;
    logic [S_W-1:0]    n_avg;
    logic [S_W-1:0]    n_peak;
    logic [T_W-1:0]    n_total;
    logic signed [S_W+1:0] diff;
    logic signed [S_W+1:0] step;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            lsm_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = lsm_pkg::ST_UPD;
                end
            end
            lsm_pkg::ST_UPD: begin
                div_start = 1'b1;
                n_state   = lsm_pkg::ST_DIV;
            end
            lsm_pkg::ST_DIV: begin
                if (!div_busy && (!r_out_valid || i_ready)) begin
                    out_load = 1'b1;
                    n_state  = lsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsm_pkg::ST_IDLE;
            end
        endcase
    end

    lsm_ram #(
        .WIDTH (S_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (div_start),
        .i_waddr (r_slot),
        .i_wdata (r_s),
        .i_re    (accept),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    // update datapath, used in ST_UPD
    always_comb begin
        full   = (r_fill == FILL_W'(RING_DEPTH));
        n_sum  = r_sum - (full ? SUM_W'(ring_rdata) : '0) + SUM_W'(r_s);
        n_fill = full ? r_fill : r_fill + FILL_W'(1);
        n_slot = (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + SLOT_W'(1);
        diff   = $signed({2'b00, r_s}) - $signed({2'b00, r_avg});
        // divide by 16 toward zero: bias negatives before the shift
        if (diff < 0) begin
            step = (diff + (S_W+2)'((1 << SH) - 1)) >>> SH;
        end else begin
            step = diff >>> SH;
        end
        n_avg   = (r_total == '0) ? r_s : r_avg + step[S_W-1:0];
        n_peak  = (r_s > r_peak) ? r_s : r_peak;
        n_total = (r_total == '1) ? r_total : r_total + T_W'(1);
    end

    lsm_div #(
        .DVD_W (SUM_W),
        .DVS_W (FILL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s      <= lsm_pkg::floor_sample(i_duration_sample);
            r_height <= i_start_height;
            r_rows   <= i_row_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_total <= '0;
            r_avg   <= '0;
            r_peak  <= '0;
        end else if (div_start) begin
            r_slot  <= n_slot;
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_total <= n_total;
            r_avg   <= n_avg;
            r_peak  <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_low  <= H_W'(r_height) + H_W'(r_rows != '0);
            r_high <= H_W'(r_height) + H_W'(r_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_total <= r_total;
            r_o_last  <= r_s;
            r_o_avg   <= r_avg;
            r_o_peak  <= r_peak;
            r_o_fill  <= r_fill;
            r_o_wavg  <= div_quot[S_W-1:0];
            r_o_low   <= r_low;
            r_o_high  <= r_high;
            r_o_rows  <= r_rows;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_total_count       = r_o_total;
    assign o_last_duration     = r_o_last;
    assign o_smoothed_duration = r_o_avg;
    assign o_peak_duration     = r_o_peak;
    assign o_window_samples    = r_o_fill;
    assign o_window_average    = r_o_wavg;
    assign o_first_height      = r_o_low;
    assign o_last_height       = r_o_high;
    assign o_batch_rows        = r_o_rows;

endmodule

`default_nettype wire

### rtl/lsm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lsm_checker #(
    parameter int RING_DEPTH = lsm_pkg::RING_DEPTH_DEF
) (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_valid,
    input wire logic                                  o_ready,
    input wire logic signed [lsm_pkg::DURATION_W-1:0] i_duration_sample,
    input wire logic        [lsm_pkg::START_W-1:0]    i_start_height,
    input wire logic        [lsm_pkg::ROWS_W-1:0]     i_row_count,
    input wire logic                                  o_valid,
    input wire logic                                  i_ready,
    input wire logic        [lsm_pkg::TOTAL_W-1:0]    o_total_count,
    input wire logic        [lsm_pkg::SAMPLE_W-1:0]   o_last_duration,
    input wire logic        [lsm_pkg::SAMPLE_W-1:0]   o_smoothed_duration,
    input wire logic        [lsm_pkg::SAMPLE_W-1:0]   o_peak_duration,
    input wire logic        [$clog2(RING_DEPTH+1)-1:0] o_window_samples,
    input wire logic        [lsm_pkg::SAMPLE_W-1:0]   o_window_average,
    input wire logic signed [lsm_pkg::HEIGHT_W-1:0]   o_first_height,
    input wire logic signed [lsm_pkg::HEIGHT_W-1:0]   o_last_height,
    input wire logic        [lsm_pkg::ROWS_W-1:0]     o_batch_rows
);

    localparam int H_W = lsm_pkg::HEIGHT_W;

    // no result appears out of reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_total_count)
                                && $stable(o_window_average))
        else $error("stalled result changed");

    // one item in flight: the input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item accepted while one is in flight");

    // averages never exceed the peak, and every result has a sample
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_duration != '0 && o_smoothed_duration != '0
                    && o_window_samples != '0
                    && o_last_duration <= o_peak_duration
                    && o_smoothed_duration <= o_peak_duration
                    && o_window_average <= o_peak_duration)
        else $error("statistics out of bounds");

    // first = start + (rows != 0), last = start + rows, both wrapped
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_first_height + H_W'(o_batch_rows)
                    == o_last_height + H_W'(o_batch_rows != '0))
        else $error("height range inconsistent with row count");

endmodule

bind latency_statistics_monitor lsm_checker #(.RING_DEPTH(RING_DEPTH)) u_lsm_checker (.*);

`default_nettype wire

### bench/latency_statistics_monitor_tb.sv
`timescale 1ns / 1ps

module latency_statistics_monitor_tb;

    localparam int TOTAL_W      = lsm_pkg::TOTAL_W;
    localparam int SAMPLE_W     = lsm_pkg::SAMPLE_W;
    localparam int HEIGHT_W     = lsm_pkg::HEIGHT_W;
    localparam int ROWS_W       = lsm_pkg::ROWS_W;
    localparam int DURATION_W   = lsm_pkg::DURATION_W;
    localparam int START_W      = lsm_pkg::START_W;

    localparam int RING         = lsm_pkg::RING_DEPTH_DEF;
    localparam int DIR_ROWS     = 20;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_FIRST   = DIR_ROWS + 300;
    localparam int CALM_LAST    = DIR_ROWS + 450;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [SAMPLE_W-1:0] last;
        logic [SAMPLE_W-1:0] smooth;
        logic [SAMPLE_W-1:0] peak;
        logic [5:0]          filled;
        logic [SAMPLE_W-1:0] wavg;
        logic [HEIGHT_W-1:0] lo;
        logic [HEIGHT_W-1:0] hi;
        logic [ROWS_W-1:0]   rows;
    } t_stats;

    typedef struct packed {
        logic [DURATION_W-1:0] dur;
        logic [START_W-1:0]    start;
        logic [ROWS_W-1:0]     rows;
        logic                  known;
        t_stats                want;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic signed [DURATION_W-1:0] i_duration_sample;
    logic [START_W-1:0]           i_start_height;
    logic [ROWS_W-1:0]            i_row_count;
    logic                         o_valid;
    logic                         i_ready;
    logic [TOTAL_W-1:0]           o_total_count;
    logic [SAMPLE_W-1:0]          o_last_duration;
    logic [SAMPLE_W-1:0]          o_smoothed_duration;
    logic [SAMPLE_W-1:0]          o_peak_duration;
    logic [5:0]                   o_window_samples;
    logic [SAMPLE_W-1:0]          o_window_average;
    logic signed [HEIGHT_W-1:0]   o_first_height;
    logic signed [HEIGHT_W-1:0]   o_last_height;
    logic [ROWS_W-1:0]            o_batch_rows;

    latency_statistics_monitor dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_duration_sample   (i_duration_sample),
        .i_start_height      (i_start_height),
        .i_row_count         (i_row_count),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_total_count       (o_total_count),
        .o_last_duration     (o_last_duration),
        .o_smoothed_duration (o_smoothed_duration),
        .o_peak_duration     (o_peak_duration),
        .o_window_samples    (o_window_samples),
        .o_window_average    (o_window_average),
        .o_first_height      (o_first_height),
        .o_last_height       (o_last_height),
        .o_batch_rows        (o_batch_rows)
    );

    // Rows 0-2 carry hand-computed statistics; the rest go through the predictor.
    t_stim_row dir_table [DIR_ROWS] = '{
        '{32'h0000_0000, 31'h0000_0000, 20'h00000, 1'b1,
          '{32'd1, 31'd1, 31'd1, 31'd1, 6'd1, 31'd1, 32'h0000_0000, 32'h0000_0000, 20'h00000}},
        '{32'h8000_0000, 31'h7FFF_FFFF, 20'hFFFFF, 1'b1,
          '{32'd2, 31'd1, 31'd1, 31'd1, 6'd2, 31'd1, 32'h8000_0000, 32'h800F_FFFE, 20'hFFFFF}},
        '{32'hFFFF_FFFF, 31'd5, 20'd1, 1'b1,
          '{32'd3, 31'd1, 31'd1, 31'd1, 6'd3, 31'd1, 32'd6, 32'd6, 20'd1}},
        '{32'h7FFF_FFFF, 31'h0000_0000, 20'h00000, 1'b0, '0},
        '{32'h0000_0001, 31'h5555_5555, 20'h55555, 1'b0, '0},
        '{32'h5555_5555, 31'h2AAA_AAAA, 20'hAAAAA, 1'b0, '0},
        '{32'h2AAA_AAAA, 31'h7FFF_FFFF, 20'h00001, 1'b0, '0},
        '{32'h0000_0002, 31'h0000_0000, 20'hFFFFF, 1'b0, '0},
        '{32'h8000_0001, 31'd100,       20'h00000, 1'b0, '0},
        '{32'h0000_0011, 31'd1,         20'd2,     1'b0, '0},
        '{32'h4000_0000, 31'h4000_0000, 20'h80000, 1'b0, '0},
        '{32'd16,        31'h0000_FFFF, 20'd1,     1'b0, '0},
        '{32'd15,        31'h7FFF_FFFE, 20'd2,     1'b0, '0},
        '{32'hFFFF_FFF0, 31'd3,         20'd0,     1'b0, '0},
        '{32'd1000,      31'd0,         20'd10,    1'b0, '0},
        '{32'd1016,      31'd1,         20'd11,    1'b0, '0},
        '{32'd984,       31'd2,         20'd12,    1'b0, '0},
        '{32'd3,         31'd3,         20'd13,    1'b0, '0},
        '{32'h7FFF_FFFE, 31'd4,         20'd14,    1'b0, '0},
        '{32'd1,         31'd5,         20'd15,    1'b0, '0}
    };

    // predictor state
    logic [SAMPLE_W-1:0] ring_mem [RING];
    int unsigned         slot_idx = 0;
    int unsigned         filled = 0;
    logic [63:0]         win_acc = '0;
    logic [TOTAL_W-1:0]  count_total = '0;
    logic [SAMPLE_W-1:0] ewma_s = '0;
    logic [SAMPLE_W-1:0] peak_s = '0;

    t_stats stats_due [$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     items_sent = 0;
    int     floored_sent = 0;
    int     idle_count = 0;
    bit     steady = 1'b0;

    function automatic t_stats predict_stats(input logic [DURATION_W-1:0] dur,
                                             input logic [START_W-1:0] start,
                                             input logic [ROWS_W-1:0] rows);
        t_stats           r;
        logic [SAMPLE_W-1:0] s;
        longint           diff;
        s = (dur[DURATION_W-1] || dur == '0) ? SAMPLE_W'(1) : dur[SAMPLE_W-1:0];
        // full ring: oldest sample leaves the sum
        if (filled >= RING) win_acc = win_acc - ring_mem[slot_idx];
        ring_mem[slot_idx] = s;
        win_acc = win_acc + s;
        slot_idx = (slot_idx + 1) % RING;
        if (filled < RING) filled++;
        if (count_total == '0) begin
            ewma_s = s;
        end else begin
            diff = longint'(s) - longint'(ewma_s);
            ewma_s = SAMPLE_W'(longint'(ewma_s) + diff / 16);
        end
        if (s > peak_s) peak_s = s;
        if (count_total != '1) count_total++;
        r.total  = count_total;
        r.last   = s;
        r.smooth = ewma_s;
        r.peak   = peak_s;
        r.filled = 6'(filled);
        r.wavg   = SAMPLE_W'(win_acc / filled);
        r.lo     = {1'b0, start} + HEIGHT_W'(rows != '0);
        r.hi     = {1'b0, start} + HEIGHT_W'(rows);
        r.rows   = rows;
        return r;
    endfunction

    task automatic random_item(output logic [DURATION_W-1:0] dur,
                               output logic [START_W-1:0] start,
                               output logic [ROWS_W-1:0] rows);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)       dur = '0;
        else if (pick < 12) dur = {1'b1, 31'($urandom)};
        else if (pick < 16) dur = pick[0] ? 32'h7FFF_FFFF : 32'd1;
        else if (pick < 35) dur = {1'b0, 31'($urandom)};
        else                dur = $urandom_range(1, 5000);
        pick = $urandom_range(0, 99);
        if (pick < 20) start = 31'h7FFF_FFFF - 31'($urandom_range(0, 2000000));
        else           start = 31'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)      rows = '0;
        else if (pick < 20) rows = '1;
        else if (pick < 50) rows = 20'($urandom);
        else                rows = 20'($urandom_range(0, 1000));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side
    always @(posedge i_clk) begin
        t_stats want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (stats_due.size() == 0) begin
                $error("result with no item outstanding");
                mismatches++;
            end else begin
                want = stats_due.pop_front();
                check_field("total_count", want.total, o_total_count);
                check_field("last_duration", want.last, o_last_duration);
                check_field("smoothed_duration", want.smooth, o_smoothed_duration);
                check_field("peak_duration", want.peak, o_peak_duration);
                check_field("window_samples", want.filled, o_window_samples);
                check_field("window_average", want.wavg, o_window_average);
                check_field("first_height", want.lo, o_first_height);
                check_field("last_height", want.hi, o_last_height);
                check_field("batch_rows", want.rows, o_batch_rows);
            end
        end
        i_ready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_count <= 0;
        end else if (i_rst_n) begin
            idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("timeout: no item moved in %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [DURATION_W-1:0] dur;
        logic [START_W-1:0]    start;
        logic [ROWS_W-1:0]     rows;
        t_stats                predicted;
        bit                    calm;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_ready           = 1'b0;
        i_duration_sample = '0;
        i_start_height    = '0;
        i_row_count       = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int idx = 0; idx < DIR_ROWS + RANDOM_ITEMS; idx++) begin
            if (idx < DIR_ROWS) begin
                dur   = dir_table[idx].dur;
                start = dir_table[idx].start;
                rows  = dir_table[idx].rows;
            end else begin
                random_item(dur, start, rows);
            end
            calm = (idx >= CALM_FIRST && idx < CALM_LAST);
            steady <= calm;
            while (!calm && $urandom_range(0, 99) < 30) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid           <= 1'b1;
            i_duration_sample <= dur;
            i_start_height    <= start;
            i_row_count       <= rows;
            do @(posedge i_clk); while (!o_ready);
            predicted = predict_stats(dur, start, rows);
            if (idx < DIR_ROWS && dir_table[idx].known) stats_due.push_back(dir_table[idx].want);
            else stats_due.push_back(predicted);
            items_sent++;
            if (dur[DURATION_W-1] || dur == '0) floored_sent++;
        end
        i_valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("%0d items sent (%0d floored to one), %0d results checked", items_sent,
                 floored_sent, results_seen);
        $display("ring wrapped %0d times; extremes, height wrap and stalls on both sides covered",
                 items_sent / RING);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
